>>> sv/shp_pkg.sv
// Shared types, constants and the per-channel sharpen arithmetic for the
// 3x3 RGB sharpen stream. No dependencies.
`default_nettype none

package shp_pkg;

  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;
  localparam int ROW_W    = 12;
  localparam int OCOL_W   = 11;
  localparam int WID_W    = 12;
  localparam int HGT_W    = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 1;
  localparam int DIM_MIN  = 3;
  localparam int HGT_MAX  = 4096;
  localparam int SUM_W    = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WID_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd480;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [PIX_W-1:0] pixel_t;

  // 5*c - t - l - r - b, clamped to 0..255. The 12-bit sum wraps the same
  // way signed arithmetic would, since the true range is -1020..1275.
  function automatic chan_t sharpen_chan(chan_t t, chan_t l, chan_t c,
                                         chan_t r, chan_t b);
    logic [SUM_W-1:0]        sum;
    logic signed [SUM_W-1:0] v;
    chan_t                   res;
    sum = {2'b00, c, 2'b00} + {4'b0000, c} - {4'b0000, t} - {4'b0000, l}
        - {4'b0000, r} - {4'b0000, b};
    v = $signed(sum);
    if (v < 0) begin
      res = '0;
    end else if (v > 12'sd255) begin
      res = '1;
    end else begin
      res = sum[CH_W-1:0];
    end
    return res;
  endfunction

  function automatic pixel_t sharpen_px(pixel_t t, pixel_t l, pixel_t c,
                                        pixel_t r, pixel_t b);
    pixel_t res;
    for (int k = 0; k < 3; k++) begin
      res[k*CH_W +: CH_W] = sharpen_chan(t[k*CH_W +: CH_W], l[k*CH_W +: CH_W],
                                         c[k*CH_W +: CH_W], r[k*CH_W +: CH_W],
                                         b[k*CH_W +: CH_W]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> sv/shp_line_buf.sv
// Two-row line store (upper and middle rows packed per column) with a
// registered read port and a write-to-read bypass. Uses shp_pkg.
`default_nettype none

module shp_line_buf
  import shp_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               rd_en,
  input  wire logic [AW-1:0]      rd_addr,
  output logic      [2*PIX_W-1:0] rd_data,
  input  wire logic               wr_en,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire logic [2*PIX_W-1:0] wr_data
);

  logic [2*PIX_W-1:0] mem [DEPTH];
  logic [2*PIX_W-1:0] rd_q_r;
  logic [2*PIX_W-1:0] byp_data_r;
  logic               byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read that meets a write to the same column in the same cycle must
  // see the new data, so the written word is captured alongside.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_r      <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

`default_nettype wire

>>> sv/sharpen_3x3_rgb_stream.sv
// Top level of the 3x3 sharpen filter over a raster RGB pixel stream.
// Depends on shp_pkg and shp_line_buf.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------------
//   in      | in_valid / in_stall    | in_frame_start, in_red_in, in_green_in,
//           |                        | in_blue_in
//   out     | out_valid / out_stall  | out_red_out, out_green_out, out_blue_out,
//           |                        | out_row, out_col, out_frame_done
//   cfg     | cfg_we (no handshake)  | cfg_index, cfg_data
//
// One word is accepted every cycle when the output side keeps up. A word
// passes the middle stage, where the line store read is registered, and then
// the output register, which takes the kernel arithmetic. Reset is
// synchronous and active low; it clears the counters, the window and the
// valid flags, and loads 640 x 480. A stalled output only holds back input
// when the word waiting in the middle stage itself has a result to deliver.
`default_nettype none

module sharpen_3x3_rgb_stream
  import shp_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Configuration port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // Input words
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_frame_start,
  input  wire logic [CH_W-1:0]      in_red_in,
  input  wire logic [CH_W-1:0]      in_green_in,
  input  wire logic [CH_W-1:0]      in_blue_in,
  // Result words
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CH_W-1:0]           out_red_out,
  output logic [CH_W-1:0]           out_green_out,
  output logic [CH_W-1:0]           out_blue_out,
  output logic [ROW_W-1:0]          out_row,
  output logic [OCOL_W-1:0]         out_col,
  output logic                      out_frame_done
);

  localparam int CW    = $clog2(MAX_WIDTH);  // column counter and address
  localparam int W_CMP = CW + 1;             // holds MAX_WIDTH itself

  // ---------------------------------------------------------------------
  // Configuration registers and the clamped frame size in use.
  // ---------------------------------------------------------------------
  logic [WID_W-1:0] image_width_r;
  logic [HGT_W-1:0] image_height_r;
  logic [W_CMP-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RST;
      image_height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[WID_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = W_CMP'(MAX_WIDTH);
    end else if (32'(image_width_r) < 32'(DIM_MIN)) begin
      w_eff = W_CMP'(DIM_MIN);
    end else begin
      w_eff = W_CMP'(image_width_r);
    end
    if (32'(image_height_r) > 32'(HGT_MAX)) begin
      h_eff = HGT_W'(HGT_MAX);
    end else if (32'(image_height_r) < 32'(DIM_MIN)) begin
      h_eff = HGT_W'(DIM_MIN);
    end else begin
      h_eff = image_height_r;
    end
  end

  // ---------------------------------------------------------------------
  // Entry: raster position of the incoming word. Counters advance as the
  // word is accepted; frame_start restarts the position at this word.
  // ---------------------------------------------------------------------
  logic              in_acc;
  logic [CW-1:0]     col_cnt_r;
  logic [ROW_W-1:0]  row_cnt_r;
  logic [CW-1:0]     col0;
  logic [ROW_W-1:0]  row0;
  logic [W_CMP-1:0]  col_p1;
  logic [HGT_W-1:0]  row_p1;
  logic              last_col;
  logic              last_row;
  logic              emit0;
  logic [CW-1:0]     col_m2;

  assign in_acc   = in_valid && !in_stall;
  assign col0     = in_frame_start ? '0 : col_cnt_r;
  assign row0     = in_frame_start ? '0 : row_cnt_r;
  assign col_p1   = {1'b0, col0} + W_CMP'(1);
  assign row_p1   = {1'b0, row0} + HGT_W'(1);
  assign last_col = col_p1 >= w_eff;
  assign last_row = row_p1 >= h_eff;
  // A full 3x3 window exists once two rows and two columns precede this word.
  assign emit0    = (row0 >= ROW_W'(2)) && (col0 >= CW'(2));
  assign col_m2   = col0 - CW'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_cnt_r <= '0;
        row_cnt_r <= last_row ? '0 : row_p1[ROW_W-1:0];
      end else begin
        col_cnt_r <= col_p1[CW-1:0];
        row_cnt_r <= row0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Middle stage: the word with its column's two stored rows, read from
  // the line store at acceptance.
  // ---------------------------------------------------------------------
  logic               s1_valid_r;
  logic               s1_adv;
  pixel_t             s1_bot_r;
  logic [CW-1:0]      s1_col_r;
  logic               s1_emit_r;
  logic [ROW_W-1:0]   s1_orow_r;
  logic [OCOL_W-1:0]  s1_ocol_r;
  logic               s1_done_r;
  logic [2*PIX_W-1:0] lb_rd_data;
  pixel_t             s1_up;
  pixel_t             s1_mid;

  assign s1_up  = lb_rd_data[2*PIX_W-1:PIX_W];
  assign s1_mid = lb_rd_data[PIX_W-1:0];

  // Words without a result never wait on the output register.
  assign s1_adv   = s1_valid_r && (!s1_emit_r || !out_valid || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_bot_r  <= {in_red_in, in_green_in, in_blue_in};
      s1_col_r  <= col0;
      s1_emit_r <= emit0;
      s1_orow_r <= row0 - ROW_W'(2);
      s1_ocol_r <= OCOL_W'(col_m2);
      s1_done_r <= last_col && last_row;
    end
  end

  // The line store shifts the column down a row as each word leaves the
  // middle stage: the middle row moves up, the new word becomes the middle.
  shp_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col0),
    .rd_data (lb_rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data ({s1_mid, s1_bot_r})
  );

  // ---------------------------------------------------------------------
  // Window registers: the previous column's three rows, plus the middle
  // row of the column before it. The current column's middle row comes
  // straight from the line store and serves as the right-hand tap.
  // ---------------------------------------------------------------------
  pixel_t win_top_r;
  pixel_t win_ctr_r;
  pixel_t win_bot_r;
  pixel_t win_left_r;
  pixel_t sharp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_top_r  <= '0;
      win_ctr_r  <= '0;
      win_bot_r  <= '0;
      win_left_r <= '0;
    end else if (s1_adv) begin
      win_left_r <= win_ctr_r;
      win_top_r  <= s1_up;
      win_ctr_r  <= s1_mid;
      win_bot_r  <= s1_bot_r;
    end
  end

  assign sharp = sharpen_px(win_top_r, win_left_r, win_ctr_r, s1_mid, win_bot_r);

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  logic              out_valid_r;
  pixel_t            out_px_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [OCOL_W-1:0] out_col_r;
  logic              out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_px_r   <= sharp;
      out_row_r  <= s1_orow_r;
      out_col_r  <= s1_ocol_r;
      out_done_r <= s1_done_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_out    = out_px_r[3*CH_W-1:2*CH_W];
  assign out_green_out  = out_px_r[2*CH_W-1:CH_W];
  assign out_blue_out   = out_px_r[CH_W-1:0];
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_done = out_done_r;

endmodule

`default_nettype wire

>>> sv/shp_chk.sv
// Port-level checker for sharpen_3x3_rgb_stream, bound to the top level.
// Uses shp_pkg for field widths.
`default_nettype none

module shp_chk
  import shp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [CH_W-1:0]   out_red_out,
  input wire logic [CH_W-1:0]   out_green_out,
  input wire logic [CH_W-1:0]   out_blue_out,
  input wire logic [ROW_W-1:0]  out_row,
  input wire logic [OCOL_W-1:0] out_col,
  input wire logic              out_frame_done
);

  // A held result keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_out)
      && $stable(out_green_out) && $stable(out_blue_out) && $stable(out_row)
      && $stable(out_col) && $stable(out_frame_done))
    else $error("result word changed while stalled");

  // Reset empties the output.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With nothing waiting at the output, input is never held back.
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

  // A result appearing on an empty output came from a word that went through
  // the middle stage without waiting.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without matching input word");

endmodule

bind sharpen_3x3_rgb_stream shp_chk u_shp_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_red_out    (out_red_out),
  .out_green_out  (out_green_out),
  .out_blue_out   (out_blue_out),
  .out_row        (out_row),
  .out_col        (out_col),
  .out_frame_done (out_frame_done)
);

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for sharpen_3x3_rgb_stream: pixel frames in, sharpened words checked
// against a cycle-free predictor of the filter. Depends on shp_pkg and the block's RTL.

module testbench;
  import shp_pkg::*;

  localparam int MAX_W        = 2048;
  localparam int DRAIN_CYCLES = 6;   // two pipeline stages plus margin
  localparam int MAX_REPORTS  = 40;

  // One sharpened word. The field order matches the concatenation of the out_ ports
  // in the receiver below.
  typedef struct packed {
    chan_t              red;
    chan_t              green;
    chan_t              blue;
    logic [ROW_W-1:0]   row;
    logic [OCOL_W-1:0]  col;
    logic               done;
  } sharp_px_t;

  // Directed 3x3 frame: the red cross saturates high, green saturates low, and blue
  // stays in range. Corners are all zeros and all ones, and the kernel ignores them.
  localparam pixel_t CROSS [9] = '{
    24'hFFFFFF, 24'h00FF64, 24'h000000,
    24'h00FF64, 24'hFF0064, 24'h00FF64,
    24'h000000, 24'h00FF64, 24'hFFFFFF
  };

  // Predictor of the filter plus the queue of sharpened words still owed by the block.
  class sharpen_scoreboard;
    pixel_t            upper_line [MAX_W];
    pixel_t            middle_line [MAX_W];
    pixel_t            win [6];          // [0..2] two columns back, [3..5] one column back
    int unsigned       row_cnt;
    int unsigned       col_cnt;
    logic [WID_W-1:0]  img_width;
    logic [HGT_W-1:0]  img_height;
    sharp_px_t         expected_px [$];
    int                errors;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_cnt    = 0;
      col_cnt    = 0;
      img_width  = WIDTH_RST;
      img_height = HEIGHT_RST;
      errors     = 0;
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = img_width;
      if (w < DIM_MIN) w = DIM_MIN;
      if (w > MAX_W) w = MAX_W;
      return w;
    endfunction

    function int unsigned eff_height();
      int unsigned h;
      h = img_height;
      if (h < DIM_MIN) h = DIM_MIN;
      if (h > HGT_MAX) h = HGT_MAX;
      return h;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) img_width = value[WID_W-1:0];
      else if (idx == REG_IMAGE_HEIGHT) img_height = value[HGT_W-1:0];
    endfunction

    function bit at_frame_top();
      return row_cnt == 0 && col_cnt == 0;
    endfunction

    function int pending();
      return expected_px.size();
    endfunction

    function chan_t kernel_chan(pixel_t t, pixel_t l, pixel_t c, pixel_t r, pixel_t b,
                                int k);
      int acc;
      acc = 5 * int'(c[k*CH_W +: CH_W]) - int'(t[k*CH_W +: CH_W])
          - int'(l[k*CH_W +: CH_W]) - int'(r[k*CH_W +: CH_W]) - int'(b[k*CH_W +: CH_W]);
      if (acc < 0) return '0;
      if (acc > 255) return '1;
      return chan_t'(acc);
    endfunction

    // Called once per accepted pixel word.
    function void take_pixel(bit frame_start, pixel_t px);
      int unsigned w, h, col, row;
      pixel_t      up, mid;
      sharp_px_t   res;
      w = eff_width();
      h = eff_height();
      if (frame_start) begin
        row_cnt = 0;
        col_cnt = 0;
      end
      col = col_cnt % MAX_W;
      row = row_cnt;
      up  = upper_line[col];
      mid = middle_line[col];
      if (row >= 2 && col >= 2) begin
        // The cross is centered one row up and one column left of the incoming pixel.
        res.red   = kernel_chan(win[3], win[1], win[4], mid, win[5], 2);
        res.green = kernel_chan(win[3], win[1], win[4], mid, win[5], 1);
        res.blue  = kernel_chan(win[3], win[1], win[4], mid, win[5], 0);
        res.row   = ROW_W'(row - 2);
        res.col   = OCOL_W'(col - 2);
        res.done  = (col + 1 >= w) && (row + 1 >= h);
        expected_px = {expected_px, res};
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = up;
      win[4] = mid;
      win[5] = px;
      upper_line[col]  = mid;
      middle_line[col] = px;
      if (col + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col_cnt = col + 1;
      end
    endfunction

    task check_result(sharp_px_t got);
      sharp_px_t want;
      if (expected_px.size() == 0) begin
        report($sformatf("unexpected word at row %0d col %0d", got.row, got.col));
        return;
      end
      want = expected_px.pop_front();
      if (got.red !== want.red)
        report($sformatf("red at (%0d,%0d): got %0d, want %0d",
                         want.row, want.col, got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green at (%0d,%0d): got %0d, want %0d",
                         want.row, want.col, got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue at (%0d,%0d): got %0d, want %0d",
                         want.row, want.col, got.blue, want.blue));
      if (got.row !== want.row)
        report($sformatf("row: got %0d, want %0d", got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("col at row %0d: got %0d, want %0d", want.row, got.col, want.col));
      if (got.done !== want.done)
        report($sformatf("frame_done at (%0d,%0d): got %b, want %b",
                         want.row, want.col, got.done, want.done));
    endtask

    // Every mismatch counts; only the first few are printed so a badly broken
    // block does not flood the log.
    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask
  endclass

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_W-1:0]     cfg_data       = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_frame_start = 1'b0;
  logic [CH_W-1:0]      in_red_in      = '0;
  logic [CH_W-1:0]      in_green_in    = '0;
  logic [CH_W-1:0]      in_blue_in     = '0;
  logic                 out_stall      = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [CH_W-1:0]      out_red_out;
  logic [CH_W-1:0]      out_green_out;
  logic [CH_W-1:0]      out_blue_out;
  logic [ROW_W-1:0]     out_row;
  logic [OCOL_W-1:0]    out_col;
  logic                 out_frame_done;

  sharpen_scoreboard chk;
  int idle_pct  = 0;   // chance per cycle that the pixel source holds back
  int stall_pct = 0;   // chance per cycle that the result sink stalls
  int sent      = 0;

  sharpen_3x3_rgb_stream #(.MAX_WIDTH(MAX_W)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frame_start (in_frame_start),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_done (out_frame_done)
  );

  always #5 clk = ~clk;

  // Result sink. Signals are sampled at the rising edge before any of this edge's
  // updates land, so a word counts exactly when the block sees it taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      chk.check_result({out_red_out, out_green_out, out_blue_out,
                        out_row, out_col, out_frame_done});
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Channel values that land on the clamps much more often than uniform values.
  function automatic chan_t rand_chan();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    return {rand_chan(), rand_chan(), rand_chan()};
  endfunction

  // Offers one pixel word, with random idle cycles ahead of it, and returns at the
  // edge where it is taken. Valid stays high into the next call unless that call idles.
  task automatic send_pixel(bit fs, pixel_t px);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_frame_start <= fs;
    {in_red_in, in_green_in, in_blue_in} <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chk.take_pixel(fs, px);
    sent++;
  endtask

  // Lets every owed word come out, then lets trailing words without a result
  // leave the pipeline too.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
    chk.write_reg(idx, CFG_W'(value));
    cfg_we <= 1'b0;
  endtask

  // One frame of random size and content. Width and height are set while the
  // block is idle. A larger width is only ever used from the top of a frame, so
  // rows 0 and 1 refill the line stores before any window reads them; shrinking
  // the width is safe at any point since the narrower columns were all written.
  // mid_change: 0 none, 1 shrink the width mid-frame, 2 change the height mid-frame.
  task automatic random_frame(int mid_change);
    int unsigned w, h, n, change_at, k;
    bit          first_fs, fs;
    w = ($urandom_range(7) == 0) ? $urandom_range(13, 48) : $urandom_range(3, 12);
    if (mid_change == 0 && $urandom_range(5) == 0) mid_change = $urandom_range(1, 2);
    if (mid_change == 1 && w < 5) w = 5;
    h = $urandom_range(3, 7);
    // Writes below the minimum must clamp to three.
    set_reg(REG_IMAGE_WIDTH, (w == 3 && $urandom_range(1) == 1) ? $urandom_range(2) : w);
    set_reg(REG_IMAGE_HEIGHT, (h == 3 && $urandom_range(1) == 1) ? $urandom_range(2) : h);
    n = w * h;
    // Some frames are cut short; the next one then has to restart with frame_start.
    if (mid_change == 0 && $urandom_range(7) == 0) n = $urandom_range(1, n - 1);
    change_at = $urandom_range(1, n - 1);
    // A frame can follow without frame_start only when the counters have wrapped.
    first_fs = chk.at_frame_top() ? bit'($urandom_range(1)) : 1'b1;
    for (k = 0; k < n; k++) begin
      if (mid_change != 0 && k == change_at) begin
        if (mid_change == 1) set_reg(REG_IMAGE_WIDTH, $urandom_range(3, w - 1));
        else set_reg(REG_IMAGE_HEIGHT, $urandom_range(3, 8));
      end
      // A stray frame_start now and then restarts the frame mid-way.
      fs = (k == 0) ? first_fs : ($urandom_range(63) == 0);
      send_pixel(fs, rand_pixel());
    end
  endtask

  task automatic run_phase(int idle, int stall, int items, int first_change);
    int target, frame_no;
    idle_pct  = idle;
    stall_pct = stall;
    target    = sent + items;
    frame_no  = 0;
    while (sent < target) begin
      random_frame(frame_no == 0 ? first_change : 0);
      frame_no++;
    end
  endtask

  // A run at a fixed geometry with random pixels, sender and sink at full rate.
  task automatic bulk_frame(int unsigned width_val, int unsigned height_val, int count);
    int k;
    idle_pct  = 0;
    stall_pct = 0;
    set_reg(REG_IMAGE_WIDTH, width_val);
    set_reg(REG_IMAGE_HEIGHT, height_val);
    for (k = 0; k < count; k++) send_pixel(k == 0, rand_pixel());
  endtask

  initial begin
    int k;
    chk = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: smallest frame with the clamps hit on both sides, then the same
    // frame inverted without frame_start (the counters wrapped after the first),
    // then a two-pixel fragment that the next frame must restart over.
    idle_pct  = 29;
    stall_pct = 29;
    set_reg(REG_IMAGE_WIDTH, 2);
    set_reg(REG_IMAGE_HEIGHT, 0);
    for (k = 0; k < 9; k++) send_pixel(k == 0, CROSS[k]);
    for (k = 0; k < 9; k++) send_pixel(1'b0, ~CROSS[k]);
    send_pixel(1'b1, 24'h000000);
    send_pixel(1'b0, 24'hFFFFFF);

    // Random frames at full rate, with a width shrink mid-frame in the first.
    run_phase(0, 0, 50, 1);

    // Out-of-range writes: width clamps up to three and height down to 4096, so
    // no word in this short run may carry frame_done.
    bulk_frame(0, 8191, 30);

    run_phase(84, 0, 50, 2);
    run_phase(0, 84, 50, 0);
    run_phase(29, 29, 50, 0);

    wait_idle();
    if (chk.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
